// ===== sv/es2c_pkg.sv =====
// -----------------------------------------------------------------------------
// es2c_pkg
// Types, constants and small tables shared by the epoch-to-calendar blocks.
// -----------------------------------------------------------------------------
`default_nettype none

package es2c_pkg;

    // Shared divider geometry
    localparam int QW                = 60;   // dividend / quotient register width
    localparam int RW                = 18;   // remainder / divisor width
    localparam int DIV_BITS_PER_STEP = 4;    // quotient bits retired per cycle
    localparam int STEP_W            = 4;    // width of the step counter

    // Divisors
    localparam logic [RW-1:0] SECS_PER_DAY  = 18'd86400;
    localparam logic [RW-1:0] DAYS_400Y     = 18'd146097;
    localparam logic [RW-1:0] DAYS_100Y     = 18'd36524;
    localparam logic [RW-1:0] DAYS_4Y       = 18'd1461;
    localparam logic [RW-1:0] DAYS_1Y       = 18'd365;
    localparam logic [RW-1:0] DAYS_PER_WEEK = 18'd7;
    localparam logic [RW-1:0] SECS_PER_HOUR = 18'd3600;
    localparam logic [RW-1:0] SECS_PER_MIN  = 18'd60;

    // Accepted input range
    localparam logic signed [63:0] LOW_BOUND  = -64'sd2147483648 * 64'sd31622400;
    localparam logic signed [63:0] HIGH_BOUND = 64'sd2147483647 * 64'sd31622400;

    // Day count is taken from 2000-03-01 and shifted up by a whole number of
    // 400-year eras so every dividend stays non-negative.
    localparam logic signed [63:0] MARCH_2000  = 64'sd946684800 + 64'sd86400 * 64'sd60;
    localparam logic signed [63:0] ERA_OFFSET  = 64'sd8388608;
    localparam logic signed [63:0] SECS_OFFSET =
        ERA_OFFSET * 64'sd146097 * 64'sd86400 - MARCH_2000;
    // Era shift in years, less the 100 years between 1900 and 2000
    localparam logic signed [35:0] YEAR_BIAS = 36'(ERA_OFFSET * 64'sd400 - 64'sd100);

    typedef enum logic [2:0] {
        OP_DAY  = 3'd0,
        OP_ERA  = 3'd1,
        OP_WDAY = 3'd2,
        OP_CENT = 3'd3,
        OP_QUAD = 3'd4,
        OP_YEAR = 3'd5,
        OP_HOUR = 3'd6,
        OP_MIN  = 3'd7
    } t_op;

    typedef struct packed {
        logic take_in;
        logic load;
        logic start;
        t_op  op;
        logic fin_a;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic oob;
        logic div_busy;
        logic div_done;
    } t_sts;

    typedef struct packed {
        logic               status;
        logic signed [31:0] year_since_1900;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
        logic [2:0]         weekday;
        logic [8:0]         day_of_year;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
    } t_result;

    function automatic logic [RW-1:0] op_divisor(input t_op op);
        case (op)
            OP_DAY:  return SECS_PER_DAY;
            OP_ERA:  return DAYS_400Y;
            OP_WDAY: return DAYS_PER_WEEK;
            OP_CENT: return DAYS_100Y;
            OP_QUAD: return DAYS_4Y;
            OP_YEAR: return DAYS_1Y;
            OP_HOUR: return SECS_PER_HOUR;
            OP_MIN:  return SECS_PER_MIN;
            default: return SECS_PER_DAY;
        endcase
    endfunction

    // Iteration steps per division: dividend bits / DIV_BITS_PER_STEP
    function automatic logic [STEP_W-1:0] op_steps(input t_op op);
        case (op)
            OP_DAY:  return 4'd15;
            OP_ERA:  return 4'd11;
            OP_WDAY: return 4'd5;
            OP_CENT: return 4'd5;
            OP_QUAD: return 4'd4;
            OP_YEAR: return 4'd3;
            OP_HOUR: return 4'd5;
            OP_MIN:  return 4'd3;
            default: return 4'd15;
        endcase
    endfunction

    function automatic t_op next_op(input t_op op);
        case (op)
            OP_DAY:  return OP_ERA;
            OP_ERA:  return OP_WDAY;
            OP_WDAY: return OP_CENT;
            OP_CENT: return OP_QUAD;
            OP_QUAD: return OP_YEAR;
            OP_YEAR: return OP_HOUR;
            OP_HOUR: return OP_MIN;
            OP_MIN:  return OP_DAY;
            default: return OP_DAY;
        endcase
    endfunction

    // First day of each month in a March-based year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        case (m)
            4'd0:    return 9'd0;
            4'd1:    return 9'd31;
            4'd2:    return 9'd61;
            4'd3:    return 9'd92;
            4'd4:    return 9'd122;
            4'd5:    return 9'd153;
            4'd6:    return 9'd184;
            4'd7:    return 9'd214;
            4'd8:    return 9'd245;
            4'd9:    return 9'd275;
            4'd10:   return 9'd306;
            4'd11:   return 9'd337;
            default: return 9'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== sv/es2c_if.sv =====
// -----------------------------------------------------------------------------
// es2c_in_if / es2c_out_if
// Valid/ready channels for the epoch-seconds input and the calendar result.
// -----------------------------------------------------------------------------
`default_nettype none

interface es2c_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface es2c_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [31:0] year_since_1900;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [2:0]         weekday;
    logic [8:0]         day_of_year;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;

    modport source (output valid, output status, output year_since_1900, output month,
                    output day_of_month, output weekday, output day_of_year,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input status, input year_since_1900, input month,
                    input day_of_month, input weekday, input day_of_year,
                    input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

// ===== sv/es2c_div.sv =====
// -----------------------------------------------------------------------------
// es2c_div
// Iterative restoring divider, four quotient bits per cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module es2c_div import es2c_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QW-1:0]     i_dividend,
    input  logic [RW-1:0]     i_divisor,
    input  logic [STEP_W-1:0] i_steps,
    output logic [QW-1:0]     o_quotient,
    output logic [RW-1:0]     o_remainder,
    output logic              o_busy,
    output logic              o_done
);

    logic [QW-1:0]     r_q;
    logic [RW-1:0]     r_rem;
    logic [RW-1:0]     r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_done;

    logic [QW-1:0]     n_q;
    logic [RW-1:0]     n_rem;
    logic [RW:0]       trial;

    // Dividend is left-aligned; shift its top bit into the partial remainder
    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        trial = '0;
        for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
            trial = {n_rem, n_q[QW-1]};
            n_q   = {n_q[QW-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem  = RW'(trial - {1'b0, r_div});
                n_q[0] = 1'b1;
            end else begin
                n_rem = trial[RW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_steps;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == STEP_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_q;
    assign o_remainder = r_rem;
    assign o_busy      = (r_cnt != '0);
    assign o_done      = r_done;

`ifndef SYNTHESIS
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy)
        else $error("divider restarted while busy");

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == STEP_W'(1)) && !i_start |=> o_done && !o_busy)
        else $error("divider did not finish after last step");
`endif

endmodule

`default_nettype wire

// ===== sv/es2c_dp.sv =====
// -----------------------------------------------------------------------------
// es2c_dp
// Datapath: input range check, division sequence results, calendar assembly.
// -----------------------------------------------------------------------------
`default_nettype none

module es2c_dp import es2c_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic signed [63:0] i_epoch_seconds,
    output t_result            o_result
);

    logic signed [63:0] r_t;
    logic               r_oob;
    logic [57:0]        r_secs;
    logic [40:0]        r_days;
    logic [16:0]        r_sod;
    logic [23:0]        r_qc;
    logic [17:0]        r_rd;
    logic [2:0]         r_wday;
    logic [1:0]         r_cc;
    logic [4:0]         r_q4;
    logic [1:0]         r_ry;
    logic [4:0]         r_hour;
    logic [5:0]         r_minute;
    logic [5:0]         r_second;
    logic [3:0]         r_month;
    logic [4:0]         r_mday;
    logic [8:0]         r_yday;
    logic               r_carry;
    logic [33:0]        r_ypart;
    t_op                r_op;
    t_result            r_res;

    logic signed [63:0] secs_sum;
    logic [QW-1:0]      dividend;
    logic [17:0]        wd_v;
    logic [QW-1:0]      div_q;
    logic [RW-1:0]      div_rem;
    logic               div_busy;
    logic               div_done;
    logic [RW-1:0]      rem_adj;
    logic               leap;
    logic [8:0]         rd9;
    logic [3:0]         mon_cnt;
    logic [8:0]         mon_start;
    logic [9:0]         yday_a;
    logic [9:0]         ylen;
    logic [9:0]         yday_v;
    logic [4:0]         mday_v;
    logic [3:0]         month_v;
    logic               carry_v;
    logic [33:0]        ypart_v;
    logic signed [35:0] years_v;
    logic               ovf;
    t_result            res_v;

    assign secs_sum = r_t + SECS_OFFSET;
    assign wd_v     = r_rd + 18'd3;

    // Left-align each dividend so its width is a whole number of steps
    always_comb begin
        case (i_cmd.op)
            OP_DAY:  dividend = {2'b00, r_secs};
            OP_ERA:  dividend = {3'b000, r_days, 16'h0000};
            OP_WDAY: dividend = {2'b00, wd_v, 40'h0};
            OP_CENT: dividend = {2'b00, r_rd, 40'h0};
            OP_QUAD: dividend = {r_rd[15:0], 44'h0};
            OP_YEAR: dividend = {r_rd[11:0], 48'h0};
            OP_HOUR: dividend = {3'b000, r_sod, 40'h0};
            OP_MIN:  dividend = {r_sod[11:0], 48'h0};
            default: dividend = {2'b00, r_secs};
        endcase
    end

    es2c_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.start),
        .i_dividend  (dividend),
        .i_divisor   (op_divisor(i_cmd.op)),
        .i_steps     (op_steps(i_cmd.op)),
        .o_quotient  (div_q),
        .o_remainder (div_rem),
        .o_busy      (div_busy),
        .o_done      (div_done)
    );

    // Remainder when the last cycle of a capped split absorbs one more unit
    assign rem_adj = div_rem + op_divisor(r_op);

    // Month search over the March-based year
    assign rd9 = r_rd[8:0];
    always_comb begin
        mon_cnt = '0;
        for (int k = 1; k < 12; k++) begin
            if (rd9 >= month_start(4'(k))) begin
                mon_cnt = mon_cnt + 4'd1;
            end
        end
    end

    assign mon_start = month_start(mon_cnt);
    assign mday_v    = 5'(rd9 - mon_start + 9'd1);
    assign leap      = (r_ry == 2'd0) && ((r_q4 != 5'd0) || (r_cc == 2'd0));
    assign yday_a    = {1'b0, rd9} + 10'd59 + {9'd0, leap};
    assign ylen      = 10'd365 + {9'd0, leap};
    assign yday_v    = (yday_a >= ylen) ? (yday_a - ylen) : yday_a;

    always_comb begin
        if (mon_cnt >= 4'd10) begin
            month_v = mon_cnt - 4'd10;
            carry_v = 1'b1;
        end else begin
            month_v = mon_cnt + 4'd2;
            carry_v = 1'b0;
        end
    end

    assign ypart_v = 34'(r_ry) + (34'(r_q4) << 2) + 34'(r_cc) * 34'd100
                   + 34'(r_qc) * 34'd400;

    assign years_v = $signed({2'b00, r_ypart}) + $signed({35'd0, r_carry}) - YEAR_BIAS;
    assign ovf     = !((years_v[35:31] == 5'b00000) || (years_v[35:31] == 5'b11111));

    always_comb begin
        res_v = '0;
        if (r_oob || ovf) begin
            res_v.status = 1'b1;
        end else begin
            res_v.year_since_1900 = years_v[31:0];
            res_v.month           = r_month;
            res_v.day_of_month    = r_mday;
            res_v.weekday         = r_wday;
            res_v.day_of_year     = r_yday;
            res_v.hour            = r_hour;
            res_v.minute          = r_minute;
            res_v.second          = r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oob <= 1'b0;
        end else if (i_cmd.load) begin
            r_oob <= (r_t < LOW_BOUND) || (r_t > HIGH_BOUND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_t <= i_epoch_seconds;
        end
        if (i_cmd.load) begin
            r_secs <= secs_sum[57:0];
        end
        if (i_cmd.start) begin
            r_op <= i_cmd.op;
        end
        if (div_done) begin
            case (r_op)
                OP_DAY: begin
                    r_days <= div_q[40:0];
                    r_sod  <= div_rem[16:0];
                end
                OP_ERA: begin
                    r_qc <= div_q[23:0];
                    r_rd <= div_rem;
                end
                OP_WDAY: begin
                    r_wday <= div_rem[2:0];
                end
                OP_CENT: begin
                    // last day of a 400-year era stays in the fourth century
                    if (div_q[2:0] == 3'd4) begin
                        r_cc <= 2'd3;
                        r_rd <= rem_adj;
                    end else begin
                        r_cc <= div_q[1:0];
                        r_rd <= div_rem;
                    end
                end
                OP_QUAD: begin
                    if (div_q[4:0] == 5'd25) begin
                        r_q4 <= 5'd24;
                        r_rd <= rem_adj;
                    end else begin
                        r_q4 <= div_q[4:0];
                        r_rd <= div_rem;
                    end
                end
                OP_YEAR: begin
                    // leap day at the end of a 4-year cycle stays in year three
                    if (div_q[2:0] == 3'd4) begin
                        r_ry <= 2'd3;
                        r_rd <= rem_adj;
                    end else begin
                        r_ry <= div_q[1:0];
                        r_rd <= div_rem;
                    end
                end
                OP_HOUR: begin
                    r_hour <= div_q[4:0];
                    r_sod  <= div_rem[16:0];
                end
                OP_MIN: begin
                    r_minute <= div_q[5:0];
                    r_second <= div_rem[5:0];
                end
                default: begin
                    r_wday <= r_wday;
                end
            endcase
        end
        if (i_cmd.fin_a) begin
            r_month <= month_v;
            r_mday  <= mday_v;
            r_yday  <= yday_v[8:0];
            r_carry <= carry_v;
            r_ypart <= ypart_v;
        end
        if (i_cmd.out_load) begin
            r_res <= res_v;
        end
    end

    assign o_sts.oob      = r_oob;
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_result       = r_res;

`ifndef SYNTHESIS
    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && res_v.status |=>
            (r_res.year_since_1900 == 32'sd0) && (r_res.day_of_month == 5'd0)
            && (r_res.month == 4'd0))
        else $error("error result carries nonzero calendar fields");
`endif

endmodule

`default_nettype wire

// ===== sv/es2c_ctrl.sv =====
// -----------------------------------------------------------------------------
// es2c_ctrl
// Controller: sequences the eight divisions and the final assembly steps.
// -----------------------------------------------------------------------------
`default_nettype none

module es2c_ctrl import es2c_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_LAUNCH = 6'b000100,
        S_WAIT   = 6'b001000,
        S_FIN_A  = 6'b010000,
        S_FIN_B  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_op    r_op;
    t_op    n_op;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_op       = OP_DAY;
                n_state    = S_LAUNCH;
            end
            S_LAUNCH: begin
                if (i_sts.oob) begin
                    n_state = S_FIN_B;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    if (r_op == OP_MIN) begin
                        n_state = S_FIN_A;
                    end else begin
                        n_op    = next_op(r_op);
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_FIN_A: begin
                o_cmd.fin_a = 1'b1;
                n_state     = S_FIN_B;
            end
            S_FIN_B: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_DAY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_WAIT))
        else $error("divider finished outside the wait state");

    a_free_slot_unloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN_B) && !r_out_valid |=> (r_state == S_IDLE) && r_out_valid)
        else $error("result not moved into free output register");
`endif

endmodule

`default_nettype wire

// ===== sv/epoch_seconds_to_calendar_top.sv =====
// Sequence: eight constant divisions share one 4-bit-per-cycle divider, each
//   launched from S_LAUNCH and awaited in S_WAIT; then S_FIN_A and S_FIN_B
//   assemble the calendar fields and load the output register.
// Flow: one transaction at a time; an out-of-range input skips the divisions.
// Reset: synchronous active-low i_rst_n clears the controller, the divider
//   counter and the output valid flag; there is no clearing pass.
// -----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Signed Unix seconds to proleptic Gregorian UTC calendar fields.
// -----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_top import es2c_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    es2c_in_if.sink     i_in,
    es2c_out_if.source  o_out
);

    // Command and status between controller and datapath
    t_cmd    cmd;
    t_sts    sts;
    t_result result;

    // Controller: accepts one transaction in idle, walks the division
    // sequence (days, era, weekday, century, 4-year, year, hour, minute)
    // unless the input is out of range, then assembles the calendar and
    // hands it to the output register. The output register lets the next
    // transaction in while a finished result still waits for the sink.
    es2c_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: shift the seconds count by whole 400-year eras so every
    // floored division becomes an unsigned one, run the divisions on the
    // shared divider, and undo the era shift on the year at the end.
    es2c_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_epoch_seconds (i_in.epoch_seconds),
        .o_result        (result)
    );

    // Drive the result channel payload from the output register
    assign o_out.status          = result.status;
    assign o_out.year_since_1900 = result.year_since_1900;
    assign o_out.month           = result.month;
    assign o_out.day_of_month    = result.day_of_month;
    assign o_out.weekday         = result.weekday;
    assign o_out.day_of_year     = result.day_of_year;
    assign o_out.hour            = result.hour;
    assign o_out.minute          = result.minute;
    assign o_out.second          = result.second;

endmodule

`default_nettype wire

// ===== sim/tb_epoch_seconds_to_calendar_top.sv =====
// -----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_top
// Self-checking bench for the epoch-seconds to UTC calendar converter. Each
// accepted input transaction is converted by an in-bench calendar predictor
// and the expected breakdown is queued. Every result transaction is compared
// field by field with the oldest queued breakdown. Stimulus covers landmark
// dates, both year-overflow edges and a random mix, with random idling on
// both channels.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_epoch_seconds_to_calendar_top import es2c_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Calendar constants, kept separate from the design's package
    localparam longint SECS_IN_DAY      = 64'sd86400;
    localparam longint DAYS_IN_ERA      = 64'sd146097;  // 400 years
    localparam longint DAYS_IN_CENTURY  = 64'sd36524;
    localparam longint DAYS_IN_OLYMPIAD = 64'sd1461;    // 4 years
    localparam longint DAYS_IN_YEAR     = 64'sd365;
    localparam longint MARCH_2000_SECS  = 64'sd951868800;
    localparam longint EARLIEST_SECS    = -64'sd2147483648 * 64'sd31622400;
    localparam longint LATEST_SECS      = 64'sd2147483647 * 64'sd31622400;
    localparam longint YEAR_MAX         = 64'sd2147483647;
    localparam longint YEAR_MIN         = -64'sd2147483648;

    localparam int RANDOM_ITEMS = 1700;
    localparam int SETTLE_CYCLES = 100;   // idle time after the last result
    localparam int STALL_LIMIT = 1000;    // cycles with no transaction at all

    logic i_clk;
    logic i_rst_n;

    es2c_in_if  seconds_ch ();
    es2c_out_if calendar_ch ();

    epoch_seconds_to_calendar_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (seconds_ch),
        .o_out   (calendar_ch)
    );

    // Expected breakdowns, oldest first
    t_result pending_calendars[$];

    int errors = 0;
    int conversions_sent = 0;
    int calendars_checked = 0;
    int overflow_results = 0;
    bit steady_flow = 1'b0;   // when set, neither side idles

    // Year-overflow edges, found by searching the predictor
    longint last_good_late;
    longint first_bad_late;
    longint last_good_early;
    longint first_bad_early;

    // -------------------------------------------------------------------------
    // Clock and reset
    // -------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------------
    // Calendar predictor
    // -------------------------------------------------------------------------

    // Floored division for a positive divisor
    function automatic void floor_divmod(input longint num, input longint den,
                                         output longint quo, output longint rem);
        quo = num / den;
        rem = num % den;
        if (rem < 0) begin
            rem += den;
            quo -= 1;
        end
    endfunction

    // Break a signed epoch count into UTC calendar fields. The day count is
    // taken from 2000-03-01, so every leap day lands at the end of its cycle.
    function automatic t_result calendar_of(input longint t);
        t_result cal;
        longint  secs, days, sod, day_rest, era, cent, olymp, yr;
        longint  years, leap, yday, wday, mon, unused_q;
        longint  march_month_days [12];

        march_month_days = '{31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 31, 29};
        cal = '0;
        // Far beyond any 32-bit year: flag and leave the rest zero
        if (t < EARLIEST_SECS || t > LATEST_SECS) begin
            cal.status = 1'b1;
            return cal;
        end

        secs = t - MARCH_2000_SECS;
        floor_divmod(secs, SECS_IN_DAY, days, sod);
        // 2000-03-01 was a Wednesday
        floor_divmod(days + 3, 7, unused_q, wday);
        floor_divmod(days, DAYS_IN_ERA, era, day_rest);

        // The last day of an era, century or olympiad belongs to the
        // previous sub-cycle: clamp the quotient
        cent = day_rest / DAYS_IN_CENTURY;
        if (cent == 4) cent = 3;
        day_rest -= cent * DAYS_IN_CENTURY;

        olymp = day_rest / DAYS_IN_OLYMPIAD;
        if (olymp == 25) olymp = 24;
        day_rest -= olymp * DAYS_IN_OLYMPIAD;

        yr = day_rest / DAYS_IN_YEAR;
        if (yr == 4) yr = 3;
        day_rest -= yr * DAYS_IN_YEAR;

        leap = (yr == 0 && (olymp != 0 || cent == 0)) ? 1 : 0;
        yday = day_rest + 31 + 28 + leap;
        if (yday >= 365 + leap) yday -= 365 + leap;

        years = yr + 4 * olymp + 100 * cent + 400 * era;

        mon = 0;
        while (mon < 12 && march_month_days[mon] <= day_rest) begin
            day_rest -= march_month_days[mon];
            mon++;
        end
        // January and February belong to the next January-based year
        if (mon >= 10) begin
            mon -= 12;
            years++;
        end

        years += 100;
        if (years > YEAR_MAX || years < YEAR_MIN) begin
            cal.status = 1'b1;
            return cal;
        end

        cal.year_since_1900 = years[31:0];
        cal.month           = 4'(mon + 2);
        cal.day_of_month    = 5'(day_rest + 1);
        cal.weekday         = 3'(wday);
        cal.day_of_year     = 9'(yday);
        cal.hour            = 5'(sod / 3600);
        cal.minute          = 6'(sod / 60 % 60);
        cal.second          = 6'(sod % 60);
        return cal;
    endfunction

    // -------------------------------------------------------------------------
    // Input side
    // -------------------------------------------------------------------------

    // Offer one epoch count and return once it is taken. Valid stays high on
    // return, so a back-to-back transaction never drops it in between.
    task automatic send_seconds(input longint t);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            seconds_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seconds_ch.valid         <= 1'b1;
        seconds_ch.epoch_seconds <= t;
        do @(posedge i_clk); while (!seconds_ch.ready);
        pending_calendars.push_back(calendar_of(t));
        conversions_sent++;
    endtask

    // Drop valid and hold off until every queued breakdown has come back
    task automatic finish_pending();
        seconds_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_calendars.size() != 0);
    endtask

    // -------------------------------------------------------------------------
    // Result side: random back-pressure and field-by-field compare
    // -------------------------------------------------------------------------
    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    initial begin
        int      stall;
        t_result want;
        calendar_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                calendar_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            calendar_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!calendar_ch.valid);
            calendars_checked++;
            if (calendar_ch.status === 1'b1) overflow_results++;
            if (pending_calendars.size() == 0) begin
                $error("result transaction with no conversion outstanding");
                errors++;
            end else begin
                want = pending_calendars.pop_front();
                check_field("status", want.status, calendar_ch.status);
                check_field("year_since_1900", want.year_since_1900,
                            calendar_ch.year_since_1900);
                check_field("month", want.month, calendar_ch.month);
                check_field("day_of_month", want.day_of_month, calendar_ch.day_of_month);
                check_field("weekday", want.weekday, calendar_ch.weekday);
                check_field("day_of_year", want.day_of_year, calendar_ch.day_of_year);
                check_field("hour", want.hour, calendar_ch.hour);
                check_field("minute", want.minute, calendar_ch.minute);
                check_field("second", want.second, calendar_ch.second);
            end
        end
    end

    // -------------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long
    // -------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (seconds_ch.valid && seconds_ch.ready)
                || (calendar_ch.valid && calendar_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_epoch_seconds_to_calendar_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // -------------------------------------------------------------------------
    // Tests
    // -------------------------------------------------------------------------

    // Landmark dates: epoch, leap days at century and era ends, year ends,
    // the 32-bit seconds rollover and both sides of the coarse input bound
    task automatic test_landmark_dates();
        send_seconds(64'sd0);                        // 1970-01-01, Thursday
        send_seconds(-64'sd1);                       // 1969-12-31 23:59:59
        send_seconds(64'sh7FFF_FFFF_FFFF_FFFF);      // largest input, overflow
        send_seconds(64'sh8000_0000_0000_0000);      // smallest input, overflow
        send_seconds(LATEST_SECS);
        send_seconds(LATEST_SECS + 1);
        send_seconds(EARLIEST_SECS);
        send_seconds(EARLIEST_SECS - 1);
        send_seconds(64'sd951868799);                // 2000-02-29, era leap day
        send_seconds(64'sd951868800);                // 2000-03-01
        send_seconds(64'sd978307199);                // 2000-12-31, day_of_year 365
        send_seconds(64'sd4107542399);               // 2100-02-28, no leap day
        send_seconds(64'sd4107542400);               // 2100-03-01
        send_seconds(-64'sd2208988800);              // 1900-01-01
        send_seconds(-64'sd2203891201);              // 1900-02-28 23:59:59
        send_seconds(-64'sd2203891200);              // 1900-03-01
        send_seconds(-64'sd11670912001);             // 1600-02-29, previous era
        send_seconds(-64'sd11670912000);             // 1600-03-01
        send_seconds(64'sd2147483647);               // 32-bit rollover
    endtask

    // Locate the last in-range second at each end of the year range and hit
    // both sides of each edge
    task automatic test_year_limits();
        longint  lo, hi, mid;
        t_result probe;

        lo = 0;
        hi = LATEST_SECS;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            probe = calendar_of(mid);
            if (probe.status) hi = mid;
            else lo = mid;
        end
        last_good_late = lo;
        first_bad_late = hi;

        lo = EARLIEST_SECS;
        hi = 0;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            probe = calendar_of(mid);
            if (probe.status) lo = mid;
            else hi = mid;
        end
        last_good_early = hi;
        first_bad_early = lo;

        send_seconds(last_good_late - 1);
        send_seconds(last_good_late);
        send_seconds(first_bad_late);
        send_seconds(last_good_early + 1);
        send_seconds(last_good_early);
        send_seconds(first_bad_early);
        // Hold off until the directed part has fully returned
        finish_pending();
    endtask

    // Random mix: raw 64-bit words, in-range counts, counts near the year
    // and coarse edges, day-aligned counts near midnight and counts near
    // the epoch
    task automatic test_random_conversions();
        int          kind;
        logic [63:0] raw;
        longint      t, day_num, sod;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // One stretch runs with no idling on either side
            steady_flow = (n >= 500 && n < 700);
            kind = $urandom_range(0, 99);
            raw  = {$urandom, $urandom};
            if (kind < 15) begin
                t = raw;
            end else if (kind < 45) begin
                t = longint'($signed(raw[56:0]));
            end else if (kind < 57) begin
                t = (raw[63] ? last_good_late : last_good_early)
                    + longint'($signed(raw[24:0]));
            end else if (kind < 62) begin
                t = (raw[63] ? LATEST_SECS : EARLIEST_SECS)
                    + longint'($signed(raw[15:0]));
            end else if (kind < 90) begin
                day_num = longint'($signed(raw[21:0]));
                case ($urandom_range(0, 4))
                    0: sod = 0;
                    1: sod = 1;
                    2: sod = SECS_IN_DAY - 2;
                    3: sod = SECS_IN_DAY - 1;
                    default: sod = $urandom_range(0, 86399);
                endcase
                t = day_num * SECS_IN_DAY + sod;
            end else begin
                t = longint'($signed(raw[33:0]));
            end
            send_seconds(t);
            // Let the pipeline empty now and then
            if (n % 300 == 299) finish_pending();
        end
        steady_flow = 1'b0;
    endtask

    // -------------------------------------------------------------------------
    // Sequencer
    // -------------------------------------------------------------------------
    initial begin
        i_rst_n                  = 1'b0;
        seconds_ch.valid         = 1'b0;
        seconds_ch.epoch_seconds = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_landmark_dates();
        test_year_limits();
        test_random_conversions();

        // Wait out every outstanding result, then idle a little longer so
        // that a stray extra result would still be caught
        finish_pending();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Converted %0d epoch counts (%0d overflow), incl. landmark dates,",
                 calendars_checked, overflow_results);
        $display("both year-overflow edges and random idling on both channels.");
        if (errors == 0 && pending_calendars.size() == 0) begin
            $display("tb_epoch_seconds_to_calendar_top: PASS");
        end else begin
            $display("tb_epoch_seconds_to_calendar_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/es2c_pkg.sv
sv/es2c_if.sv
sv/es2c_div.sv
sv/es2c_dp.sv
sv/es2c_ctrl.sv
sv/epoch_seconds_to_calendar_top.sv
sim/tb_epoch_seconds_to_calendar_top.sv
